[rtl/sled_pkg.sv]
// Shared types, constants and helpers for the string literal escape decoder.
`timescale 1ns / 1ps
package sled_pkg;

  localparam int MaxRes = 5;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    KindData   = 3'd0,
    KindClosed = 3'd1,
    KindBadEsc = 3'd2,
    KindBadEnc = 3'd3,
    KindUnterm = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } sled_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } sled_out_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
  } sled_res_t;

  // All results caused by one input transfer.
  typedef struct packed {
    logic [2:0]                   cnt;
    sled_res_t [MaxRes-1:0]       res;
  } sled_desc_t;

  function automatic sled_res_t mk_data(logic [7:0] b);
    sled_res_t r;
    r.out_byte = b;
    r.kind     = KindData;
    return r;
  endfunction

  function automatic sled_res_t mk_term(kind_e k);
    sled_res_t r;
    r.out_byte = 8'h00;
    r.kind     = k;
    return r;
  endfunction

endpackage

[rtl/sled_front.sv]
// Front end: per-byte decode state machine, builds one result descriptor per transfer.
`timescale 1ns / 1ps
module sled_front
  import sled_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  sled_in_t   in_i,
  output logic       in_ready_o,
  input  logic       full_i,
  output logic       push_o,
  output sled_desc_t desc_o
);

  localparam logic [1:0] ModePlain = 2'd0;
  localparam logic [1:0] ModeEsc   = 2'd1;
  localparam logic [1:0] ModeHex   = 2'd2;
  localparam logic [1:0] ModeUtf8  = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  logic [3:0]  lim_q, lim_d;
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  hold_q [3];
  logic [7:0]  hold_d [3];

  logic       accept;
  logic [7:0] b;
  logic       eol;

  // plain content outcome
  logic       pl_has, pl_clear, pl_esc, pl_utf8;
  sled_res_t  pl_res;
  logic [2:0] pl_len;

  // hex digit and finished escape
  logic        is_hex;
  logic [3:0]  hv;
  logic [31:0] acc_new, code;
  logic        fin_bad;
  logic [2:0]  fin_cnt;
  sled_res_t   fin_res [4];

  logic [7:0] lo, hi;
  logic       cont_ok, seq_done;

  sled_desc_t desc;
  logic       clr, use_pl;
  logic [2:0] pl_base;

  assign b          = in_i.in_byte;
  assign eol        = in_i.line_end;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pl_has   = 1'b0;
    pl_clear = 1'b0;
    pl_esc   = 1'b0;
    pl_utf8  = 1'b0;
    pl_res   = mk_data(b);
    pl_len   = 3'd0;
    if (eol) begin
      pl_has   = 1'b1;
      pl_clear = 1'b1;
      pl_res   = mk_term(KindUnterm);
    end else if (b == "\"") begin
      pl_has   = 1'b1;
      pl_clear = 1'b1;
      pl_res   = mk_term(KindClosed);
    end else if (b == "\\") begin
      pl_esc = 1'b1;
    end else if (b < 8'h80) begin
      pl_has = 1'b1;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      pl_utf8 = 1'b1;
      pl_len  = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      pl_utf8 = 1'b1;
      pl_len  = 3'd3;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      pl_utf8 = 1'b1;
      pl_len  = 3'd4;
    end else begin
      pl_has   = 1'b1;
      pl_clear = 1'b1;
      pl_res   = mk_term(KindBadEnc);
    end
  end

  always_comb begin
    is_hex = 1'b1;
    hv     = b[3:0];
    if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hv = b[3:0] + 4'd9;
    end else if (!(b inside {[8'h30:8'h39]})) begin
      is_hex = 1'b0;
    end
    if (eol) begin
      is_hex = 1'b0;
    end
  end

  assign acc_new = {acc_q[27:0], hv};
  assign code    = is_hex ? acc_new : acc_q;

  always_comb begin
    fin_bad = 1'b0;
    fin_cnt = 3'd0;
    for (int i = 0; i < 4; i++) begin
      fin_res[i] = mk_data(8'h00);
    end
    if (lim_q == 4'd2) begin
      fin_cnt    = 3'd1;
      fin_res[0] = mk_data(code[7:0]);
    end else if (code != 32'd0) begin
      if (code > 32'h0010_FFFF || code inside {[32'h0000_D800:32'h0000_DFFF]}) begin
        fin_bad = 1'b1;
      end else if (code < 32'h80) begin
        fin_cnt    = 3'd1;
        fin_res[0] = mk_data(code[7:0]);
      end else if (code < 32'h800) begin
        fin_cnt    = 3'd2;
        fin_res[0] = mk_data({3'b110, code[10:6]});
        fin_res[1] = mk_data({2'b10, code[5:0]});
      end else if (code < 32'h1_0000) begin
        fin_cnt    = 3'd3;
        fin_res[0] = mk_data({4'b1110, code[15:12]});
        fin_res[1] = mk_data({2'b10, code[11:6]});
        fin_res[2] = mk_data({2'b10, code[5:0]});
      end else begin
        fin_cnt    = 3'd4;
        fin_res[0] = mk_data({5'b11110, code[20:18]});
        fin_res[1] = mk_data({2'b10, code[17:12]});
        fin_res[2] = mk_data({2'b10, code[11:6]});
        fin_res[3] = mk_data({2'b10, code[5:0]});
      end
    end
  end

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (cnt_q == 3'd1) begin
      case (hold_q[0])
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
  end

  assign cont_ok  = (b >= lo) && (b <= hi) && (cnt_q >= 3'd1) && (cnt_q <= 3'd3);
  assign seq_done = ({1'b0, cnt_q} + 4'd1) >= {1'b0, exp_q};

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    lim_d   = lim_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    desc    = '0;
    clr     = 1'b0;
    use_pl  = 1'b0;
    pl_base = 3'd0;
    case (mode_q)
      ModePlain: begin
        use_pl = 1'b1;
      end
      ModeEsc: begin
        if (eol) begin
          desc.cnt    = 3'd1;
          desc.res[0] = mk_term(KindBadEsc);
          clr         = 1'b1;
        end else begin
          desc.cnt = 3'd1;
          mode_d   = ModePlain;
          case (b)
            "'", "\"", "\\": desc.res[0] = mk_data(b);
            "a":     desc.res[0] = mk_data(8'd7);
            "b":     desc.res[0] = mk_data(8'd8);
            "f":     desc.res[0] = mk_data(8'd12);
            "e":     desc.res[0] = mk_data(8'd27);
            "n":     desc.res[0] = mk_data(8'd10);
            "r":     desc.res[0] = mk_data(8'd13);
            "t":     desc.res[0] = mk_data(8'd9);
            "v":     desc.res[0] = mk_data(8'd11);
            "x", "u", "U": begin
              desc.cnt = 3'd0;
              mode_d   = ModeHex;
              acc_d    = 32'd0;
              seen_d   = 4'd0;
              lim_d    = (b == "x") ? 4'd2 : ((b == "u") ? 4'd4 : 4'd8);
            end
            default: begin
              desc.res[0] = mk_term(KindBadEsc);
              clr         = 1'b1;
            end
          endcase
        end
      end
      ModeHex: begin
        if (is_hex) begin
          acc_d  = acc_new;
          seen_d = seen_q + 4'd1;
          if ((seen_q + 4'd1) >= lim_q) begin
            clr = 1'b1;
            if (fin_bad) begin
              desc.cnt    = 3'd1;
              desc.res[0] = mk_term(KindBadEsc);
            end else begin
              desc.cnt = fin_cnt;
              for (int i = 0; i < 4; i++) begin
                desc.res[i] = fin_res[i];
              end
            end
          end
        end else if (seen_q == 4'd0 || fin_bad) begin
          desc.cnt    = 3'd1;
          desc.res[0] = mk_term(KindBadEsc);
          clr         = 1'b1;
        end else begin
          clr      = 1'b1;
          desc.cnt = fin_cnt;
          for (int i = 0; i < 4; i++) begin
            desc.res[i] = fin_res[i];
          end
          use_pl  = 1'b1;
          pl_base = fin_cnt;
        end
      end
      ModeUtf8: begin
        if (eol || !cont_ok) begin
          desc.cnt    = 3'd1;
          desc.res[0] = mk_term(KindBadEnc);
          clr         = 1'b1;
        end else if (seq_done) begin
          for (int i = 0; i < 3; i++) begin
            if (3'(i) < cnt_q) begin
              desc.res[i] = mk_data(hold_q[i]);
            end
          end
          desc.res[cnt_q] = mk_data(b);
          desc.cnt        = cnt_q + 3'd1;
          clr             = 1'b1;
        end else begin
          hold_d[cnt_q[1:0]] = b;
          cnt_d              = cnt_q + 3'd1;
        end
      end
      default: begin
        clr    = 1'b1;
        use_pl = 1'b1;
      end
    endcase

    if (clr) begin
      mode_d = ModePlain;
      acc_d  = 32'd0;
      seen_d = 4'd0;
      lim_d  = 4'd0;
      exp_d  = 3'd0;
      cnt_d  = 3'd0;
    end

    if (use_pl) begin
      if (pl_has) begin
        desc.res[pl_base] = pl_res;
        desc.cnt          = pl_base + 3'd1;
      end
      if (pl_clear) begin
        mode_d = ModePlain;
        acc_d  = 32'd0;
        seen_d = 4'd0;
        lim_d  = 4'd0;
        exp_d  = 3'd0;
        cnt_d  = 3'd0;
      end
      if (pl_esc) begin
        mode_d = ModeEsc;
      end
      if (pl_utf8) begin
        hold_d[0] = b;
        cnt_d     = 3'd1;
        exp_d     = pl_len;
        mode_d    = ModeUtf8;
      end
    end
  end

  assign push_o = accept && (desc.cnt != 3'd0);
  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      acc_q  <= 32'd0;
      seen_q <= 4'd0;
      lim_q  <= 4'd0;
      exp_q  <= 3'd0;
      cnt_q  <= 3'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
      lim_q  <= lim_d;
      exp_q  <= exp_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= hold_d;
    end
  end

  a_utf8_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeUtf8 |-> cnt_q >= 3'd1 && cnt_q < exp_q && exp_q <= 3'd4)
    else $error("utf8 hold count out of range");

  a_hex_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeHex |-> seen_q < lim_q)
    else $error("hex digit count reached limit without finishing");

endmodule

[rtl/sled_fifo.sv]
// Short descriptor queue between the decode front end and the result sequencer.
`timescale 1ns / 1ps
module sled_fifo
  import sled_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sled_desc_t push_desc_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_vld_o,
  output sled_desc_t head_o
);

  sled_desc_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o     = cnt_q == QCntW'(QDepth);
  assign head_vld_o = cnt_q != '0;
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_vld_o)
    else $error("descriptor queue underflow");

endmodule

[rtl/sled_back.sv]
// Back end: walks each descriptor and drives one result per output transfer.
`timescale 1ns / 1ps
module sled_back
  import sled_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_vld_i,
  input  sled_desc_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sled_out_t  out_o
);

  logic       out_valid_q;
  sled_out_t  out_q;
  logic [2:0] idx_q;
  logic       load, take, is_last;
  sled_res_t  cur;

  assign load    = !out_valid_q || out_ready_i;
  assign take    = load && head_vld_i;
  assign cur     = head_i.res[idx_q];
  assign is_last = idx_q == (head_i.cnt - 3'd1);
  assign pop_o   = take && is_last;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else begin
      if (load) begin
        out_valid_q <= head_vld_i;
      end
      if (take) begin
        idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.out_byte <= cur.out_byte;
      out_q.kind     <= cur.kind;
      out_q.last     <= is_last;
    end
  end

  a_idx_in_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_i |-> head_i.cnt != 3'd0 && idx_q < head_i.cnt && head_i.cnt <= 3'(MaxRes))
    else $error("result index outside descriptor");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_vld_i |-> idx_q == 3'd0)
    else $error("result index not cleared between descriptors");

endmodule

[rtl/string_literal_escape_decoder.sv]
// Top level of the string literal escape decoder.
//
// Input channel (in_valid_i / in_ready_o / in_i): one byte of the literal body
// per transfer, starting after the opening quote; line_end marks end of buffer.
// Output channel (out_valid_o / out_ready_i / out_o): one result per transfer:
// a decoded byte, a closed mark or an error kind; last flags the final result
// caused by an input byte. Bytes that cause no result produce no transfer.
// Throughput: one input transfer per cycle unless the queue is full, and one
// output transfer per cycle while out_ready_i is high. An input byte yields 0
// to 5 results, sent in order by the back end, so output bandwidth bounds the
// sustained input rate on bursty text. With an empty queue the first result
// of a byte is queued on the transfer edge, then loaded into the output register.
// The 4-entry descriptor queue absorbs bursts; when full, in_ready_o drops.
// Output stall: the output register holds; the queue fills, then input stalls.
// Reset: decode state returns to plain content, queue and output are emptied.
`timescale 1ns / 1ps
module string_literal_escape_decoder
  import sled_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sled_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sled_out_t out_o
);

  logic       push, full, pop, head_vld;
  sled_desc_t push_desc, head;

  sled_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  sled_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .head_vld_o  (head_vld),
    .head_o      (head)
  );

  sled_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[tb/string_literal_escape_decoder_tb.sv]
// Self-checking testbench for the string literal escape decoder: random and directed bytes.
`timescale 1ns / 1ps
module string_literal_escape_decoder_tb;
  import sled_pkg::*;

  localparam int RandItems   = 236;
  localparam int CycleLimit  = 200000;
  localparam int LongHold    = 300;
  localparam int HoldAfter   = 120;
  localparam int SettleCycles = 20;
  localparam int MaxReports  = 10;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharApos      = 8'h27;
  localparam logic [7:0] CharBackslash = 8'h5C;

  typedef enum logic [1:0] {DecPlain, DecEscape, DecHex, DecMultibyte} dec_mode_e;

  typedef struct {
    sled_in_t item;
    bit       drain_first;
  } stim_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sled_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sled_out_t out_data;

  string_literal_escape_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  // decoder shadow state
  dec_mode_e   dmode = DecPlain;
  logic [31:0] code_acc = '0;
  logic [3:0]  ndig = '0;
  logic [3:0]  dig_lim = '0;
  logic [7:0]  lead_hold [3];
  logic [2:0]  seq_len = '0;
  logic [2:0]  seq_cnt = '0;
  sled_out_t   burst_q [$];
  sled_out_t   expected_q [$];

  stim_t pending [$];
  bit    drain_next = 1'b0;

  int pred_total = 0;
  int got_total  = 0;
  int n_in_acc   = 0;
  int err_cnt    = 0;
  int kind_seen [5];
  int stall_run  = 0;
  int stall_max  = 0;
  int cycle_cnt  = 0;

  int burst_left = 0;
  int gap_left   = 0;
  int phase_left = 0;
  int ready_mode = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  function automatic void emit(input logic [7:0] b, input kind_e k);
    sled_out_t r;
    r.out_byte = b;
    r.kind     = k;
    r.last     = 1'b0;
    burst_q.insert(burst_q.size(), r);
  endfunction

  function automatic void reset_decoder();
    dmode    = DecPlain;
    code_acc = '0;
    ndig     = '0;
    dig_lim  = '0;
    seq_len  = '0;
    seq_cnt  = '0;
  endfunction

  function automatic void abort_literal(input kind_e k);
    emit(8'h00, k);
    reset_decoder();
  endfunction

  function automatic void on_plain(input logic [7:0] b, input logic le);
    if (le) begin
      abort_literal(KindUnterm);
    end else if (b == CharQuote) begin
      emit(8'h00, KindClosed);
      reset_decoder();
    end else if (b == CharBackslash) begin
      dmode = DecEscape;
    end else if (b < 8'h80) begin
      emit(b, KindData);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      lead_hold[0] = b;
      seq_cnt      = 3'd1;
      seq_len      = (b <= 8'hDF) ? 3'd2 : (b <= 8'hEF) ? 3'd3 : 3'd4;
      dmode        = DecMultibyte;
    end else begin
      abort_literal(KindBadEnc);
    end
  endfunction

  function automatic void on_multibyte(input logic [7:0] b, input logic le);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (le) begin
      abort_literal(KindBadEnc);
      return;
    end
    if (seq_cnt == 3'd1) begin
      case (lead_hold[0])
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    if (b < lo || b > hi || seq_cnt < 3'd1 || seq_cnt > 3'd3) begin
      abort_literal(KindBadEnc);
    end else if (int'(seq_cnt) + 1 >= int'(seq_len)) begin
      for (int i = 0; i < int'(seq_cnt); i++) emit(lead_hold[i], KindData);
      emit(b, KindData);
      reset_decoder();
    end else begin
      lead_hold[seq_cnt] = b;
      seq_cnt = seq_cnt + 3'd1;
    end
  endfunction

  // returns 0 when the code point is rejected
  function automatic bit finish_code();
    logic [31:0] c;
    c = code_acc;
    if (dig_lim == 4'd2) begin
      emit(c[7:0], KindData);
    end else if (c != 0) begin
      if (c > 32'h10FFFF || (c >= 32'hD800 && c <= 32'hDFFF)) begin
        abort_literal(KindBadEsc);
        return 1'b0;
      end
      if (c < 32'h80) begin
        emit(c[7:0], KindData);
      end else if (c < 32'h800) begin
        emit({3'b110, c[10:6]}, KindData);
        emit({2'b10, c[5:0]}, KindData);
      end else if (c < 32'h10000) begin
        emit({4'b1110, c[15:12]}, KindData);
        emit({2'b10, c[11:6]}, KindData);
        emit({2'b10, c[5:0]}, KindData);
      end else begin
        emit({5'b11110, c[20:18]}, KindData);
        emit({2'b10, c[17:12]}, KindData);
        emit({2'b10, c[11:6]}, KindData);
        emit({2'b10, c[5:0]}, KindData);
      end
    end
    reset_decoder();
    return 1'b1;
  endfunction

  function automatic int hex_val(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'(8'h30);
    if (b >= "a" && b <= "f") return int'(b) - int'(8'h61) + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'(8'h41) + 10;
    return -1;
  endfunction

  function automatic void start_code(input logic [3:0] lim);
    dmode    = DecHex;
    code_acc = '0;
    ndig     = '0;
    dig_lim  = lim;
  endfunction

  function automatic void on_escape(input logic [7:0] b, input logic le);
    logic [7:0] v;
    if (le) begin
      abort_literal(KindBadEsc);
      return;
    end
    case (b)
      CharApos, CharQuote, CharBackslash: v = b;
      "a": v = 8'h07;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "e": v = 8'h1B;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      "v": v = 8'h0B;
      "x": begin
        start_code(4'd2);
        return;
      end
      "u": begin
        start_code(4'd4);
        return;
      end
      "U": begin
        start_code(4'd8);
        return;
      end
      default: begin
        abort_literal(KindBadEsc);
        return;
      end
    endcase
    emit(v, KindData);
    dmode = DecPlain;
  endfunction

  function automatic void on_hex(input logic [7:0] b, input logic le);
    int d;
    d = le ? -1 : hex_val(b);
    if (d >= 0) begin
      code_acc = {code_acc[27:0], d[3:0]};
      ndig = ndig + 4'd1;
      if (ndig >= dig_lim) void'(finish_code());
    end else if (ndig == 4'd0) begin
      abort_literal(KindBadEsc);
    end else if (finish_code()) begin
      on_plain(b, le);
    end
  endfunction

  // decode one accepted byte into the expected result store; returns result count
  function automatic int decode_byte(input sled_in_t x);
    sled_out_t r;
    int n;
    burst_q.delete();
    case (dmode)
      DecPlain:     on_plain(x.in_byte, x.line_end);
      DecEscape:    on_escape(x.in_byte, x.line_end);
      DecHex:       on_hex(x.in_byte, x.line_end);
      DecMultibyte: on_multibyte(x.in_byte, x.line_end);
      default: begin
        reset_decoder();
        on_plain(x.in_byte, x.line_end);
      end
    endcase
    n = burst_q.size();
    for (int i = 0; i < n; i++) begin
      r = burst_q[i];
      r.last = (i == n - 1);
      expected_q.insert(expected_q.size(), r);
    end
    return n;
  endfunction

  // ---- stimulus construction ----
  function automatic void put_byte(input logic [7:0] b);
    stim_t s;
    s.item.in_byte  = b;
    s.item.line_end = 1'b0;
    s.drain_first   = drain_next;
    drain_next      = 1'b0;
    pending.insert(pending.size(), s);
  endfunction

  function automatic void put_line_end();
    stim_t s;
    s.item.in_byte  = 8'($urandom);
    s.item.line_end = 1'b1;
    s.drain_first   = drain_next;
    drain_next      = 1'b0;
    pending.insert(pending.size(), s);
  endfunction

  function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    if ($urandom_range(0, 1)) return 8'h61 + 8'(v) - 8'd10;
    return 8'h41 + 8'(v) - 8'd10;
  endfunction

  function automatic logic [31:0] pick_code(input bit wide);
    int r;
    r = wide ? $urandom_range(0, 9) : $urandom_range(0, 5);
    case (r)
      0: return 32'h0;
      1: return $urandom_range(1, 32'h7F);
      2: return $urandom_range(32'h80, 32'h7FF);
      3: return $urandom_range(32'h800, 32'hFFFF);
      4: return $urandom_range(32'hD800, 32'hDFFF);
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'hD7FF;
          1: return 32'hE000;
          2: return 32'hFFFF;
          default: return 32'h7FF;
        endcase
      end
      6, 9: return $urandom_range(32'h10000, 32'h10FFFF);
      7: return $urandom_range(0, 1) ? 32'h10FFFF : 32'h110000;
      default: return $urandom_range(32'h110000, 32'hFFFFFFFF);
    endcase
  endfunction

  // backslash, letter, hex digits with optional leading zeros, then maybe a terminator
  function automatic void put_code_escape(input logic [7:0] letter, input int lim,
                                          input logic [31:0] code);
    int need;
    int nd;
    need = 1;
    for (int k = 1; k < 8; k++) if ((code >> (4 * k)) != 0) need = k + 1;
    nd = $urandom_range(need, lim);
    put_byte(CharBackslash);
    put_byte(letter);
    for (int k = nd - 1; k >= 0; k--) put_byte(hex_char(code[4*k +: 4]));
    if (nd < lim) begin
      case ($urandom_range(0, 5))
        0: put_byte(" ");
        1: put_byte("z");
        2: put_byte(CharQuote);
        3: put_byte(CharBackslash);
        4: put_line_end();
        default: ;
      endcase
    end
  endfunction

  // flaw: 0 clean, 1 bad lead, 2 bad continuation, 3 line end inside
  function automatic void put_utf8(input int flaw);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    int len;
    int cut;
    if (flaw == 1) begin
      if ($urandom_range(0, 1)) put_byte(8'($urandom_range(8'h80, 8'hC1)));
      else put_byte(8'($urandom_range(8'hF5, 8'hFF)));
      return;
    end
    len = $urandom_range(2, 4);
    case (len)
      2: lead = pick_in(8'hC2, 8'hDF);
      3: lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hE0 : 8'hED)
                                            : pick_in(8'hE0, 8'hEF);
      default: lead = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 8'hF0 : 8'hF4)
                                                  : pick_in(8'hF0, 8'hF4);
    endcase
    cut = (flaw == 0) ? len : $urandom_range(1, len - 1);
    put_byte(lead);
    for (int k = 1; k < len; k++) begin
      lo = 8'h80;
      hi = 8'hBF;
      if (k == 1) begin
        case (lead)
          8'hE0: lo = 8'hA0;
          8'hED: hi = 8'h9F;
          8'hF0: lo = 8'h90;
          8'hF4: hi = 8'h8F;
          default: ;
        endcase
      end
      if (k == cut) begin
        if (flaw == 3) put_line_end();
        else if (k == 1 && lo != 8'h80 && $urandom_range(0, 1))
          put_byte(pick_in(8'h80, lo - 8'd1));
        else if (k == 1 && hi != 8'hBF && $urandom_range(0, 1))
          put_byte(pick_in(hi + 8'd1, 8'hBF));
        else if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 8'h7F)));
        else put_byte(8'($urandom_range(8'hC0, 8'hFF)));
        return;
      end
      put_byte(pick_in(lo, hi));
    end
  endfunction

  function automatic void build_stimulus();
    logic [7:0] simple_esc [11];
    logic [7:0] b;
    int n_directed;
    int r;
    bit mid_pause_done;
    simple_esc = '{CharApos, CharQuote, CharBackslash, "a", "b", "f", "e", "n", "r", "t", "v"};
    mid_pause_done = 1'b0;
    // directed part
    put_byte(8'h00);
    put_byte(8'h7F);
    put_byte(CharBackslash); put_byte("e");
    put_byte(CharBackslash); put_byte("x"); put_byte("f"); put_byte("F");
    put_byte(CharBackslash); put_byte("u"); put_byte("0"); put_byte(CharQuote);
    put_byte(CharBackslash); put_byte("x"); put_byte("g");
    put_byte(8'hF4); put_byte(8'h8F); put_byte(8'hBF); put_byte(8'hBF);
    put_byte(8'hFF);
    put_byte(CharBackslash); put_line_end();
    put_byte("q"); put_line_end();
    n_directed = pending.size();
    drain_next = 1'b1;
    // random part: mostly well-formed fragments, some noise
    while (pending.size() < n_directed + RandItems) begin
      if (!mid_pause_done && pending.size() >= n_directed + 180) begin
        drain_next = 1'b1;
        mid_pause_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        b = 8'($urandom_range(0, 8'h7F));
        if (b == CharQuote || b == CharBackslash) b = "_";
        put_byte(b);
      end else if (r < 37) begin
        put_byte(CharBackslash);
        put_byte(simple_esc[$urandom_range(0, 10)]);
      end else if (r < 45) begin
        put_code_escape("x", 2, $urandom_range(0, 255));
      end else if (r < 54) begin
        put_code_escape("u", 4, pick_code(1'b0));
      end else if (r < 63) begin
        put_code_escape("U", 8, pick_code(1'b1));
      end else if (r < 75) begin
        put_utf8(0);
      end else if (r < 81) begin
        put_utf8($urandom_range(1, 3));
      end else if (r < 87) begin
        put_byte(CharQuote);
      end else if (r < 91) begin
        put_line_end();
      end else if (r < 95) begin
        put_byte(CharBackslash);
        put_byte(8'($urandom));
      end else begin
        put_byte(8'($urandom));
      end
    end
  endfunction

  // ---- clock and reset ----
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // ---- input driver ----
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() == 0 ||
                   (pending[0].drain_first && (in_valid || pred_total != got_total))) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending[0].item;
        pending.delete(0);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 10) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---- output receiver ----
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      phase_left <= 0;
      ready_mode <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in_acc >= HoldAfter) begin
      out_ready <= 1'b0;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(16, 64);
        ready_mode <= $urandom_range(0, 3);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // ---- monitor: checks output transfers, predicts from input transfers ----
  always @(posedge clk_i) begin
    sled_out_t e;
    int n;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_total <= got_total + 1;
        if (int'(out_data.kind) <= 4) kind_seen[int'(out_data.kind)]++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("unexpected result: byte %02h kind %0d last %0b",
                     out_data.out_byte, out_data.kind, out_data.last);
        end else begin
          e = expected_q.pop_front();
          if (out_data.out_byte !== e.out_byte || out_data.kind !== e.kind ||
              out_data.last !== e.last) begin
            err_cnt++;
            if (err_cnt <= MaxReports)
              $display({"mismatch: expected byte %02h kind %0d last %0b, ",
                        "got byte %02h kind %0d last %0b"},
                       e.out_byte, e.kind, e.last,
                       out_data.out_byte, out_data.kind, out_data.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        n = decode_byte(in_data);
        pred_total <= pred_total + n;
        n_in_acc   <= n_in_acc + 1;
      end
      if (in_valid && !in_ready) begin
        stall_run <= stall_run + 1;
        if (stall_run + 1 > stall_max) stall_max <= stall_run + 1;
      end else begin
        stall_run <= 0;
      end
    end
  end

  // ---- run limit ----
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_q.size());
      $display("string_literal_escape_decoder_tb: FAIL");
      $finish;
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    int left;
    int total_items;
    build_stimulus();
    total_items = pending.size();
    do @(posedge clk_i);
    while (n_in_acc != total_items || pred_total != got_total);
    repeat (SettleCycles) @(posedge clk_i);
    left = expected_q.size();
    if (left != 0) $display("%0d expected results never arrived", left);
    if (err_cnt > MaxReports) $display("%0d further mismatches not shown", err_cnt - MaxReports);
    $display({"covered %0d input bytes, %0d results: %0d data, %0d closed, ",
              "%0d escape errors, %0d encoding errors, %0d unterminated"},
             n_in_acc, got_total, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4]);
    $display({"output hold-off of %0d cycles applied, ",
              "longest input backpressure %0d cycles, %0d errors"},
             LongHold, stall_max, err_cnt);
    if (err_cnt == 0 && left == 0) begin
      $display("string_literal_escape_decoder_tb: PASS");
    end else begin
      $display("string_literal_escape_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sled_pkg.sv
rtl/sled_front.sv
rtl/sled_fifo.sv
rtl/sled_back.sv
rtl/string_literal_escape_decoder.sv
tb/string_literal_escape_decoder_tb.sv
